// ===== design/tam_pkg.sv =====
// Shared types and constants for the tremolo amplitude modulator.
package tam_pkg;

    localparam int PERIOD_W = 20;
    localparam int QUOT_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int DEPTH_W  = 16;
    localparam int GAIN_W   = 17;
    localparam int GS_W     = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_HALF_CYCLE = 2'd0;
    localparam t_cfg_idx CFG_WAVE_MODE  = 2'd1;
    localparam t_cfg_idx CFG_DEPTH      = 2'd2;

    typedef logic [1:0] t_wave;

    localparam t_wave WAVE_SQUARE   = 2'd0;
    localparam t_wave WAVE_TRIANGLE = 2'd1;
    localparam t_wave WAVE_PARABOLA = 2'd2;
    localparam t_wave WAVE_HALF     = 2'd3;

    localparam logic [PERIOD_W-1:0] RST_HALF_CYCLE = 20'd24000;
    localparam t_wave               RST_WAVE_MODE  = WAVE_TRIANGLE;
    localparam logic [DEPTH_W-1:0]  RST_DEPTH      = 16'd32768;

    // Divider result seen by the sequencer
    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_res;

endpackage

// ===== design/tam_div.sv =====
// Bit-serial restoring divider forming floor(pos * 2^16 / period), one quotient bit a cycle.
module tam_div
    import tam_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PERIOD_W-1:0] i_dividend,
    input  logic [PERIOD_W-1:0] i_divisor,
    output t_div_res            o_res
);

    localparam int STEP_CW = $clog2(QUOT_W);

    logic                r_busy;
    logic                r_done;
    logic [STEP_CW-1:0]  r_cnt;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_div;
    logic [QUOT_W-1:0]   r_quot;

    logic [PERIOD_W:0]   n_shift;
    logic [PERIOD_W:0]   n_diff;
    logic                n_ge;

    // Remainder stays below the divisor, so the doubled value fits one extra bit
    always_comb begin
        n_shift = {r_rem, 1'b0};
        n_diff  = n_shift - {1'b0, r_div};
        n_ge    = (n_shift >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
                r_rem  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_ge ? n_diff[PERIOD_W-1:0] : n_shift[PERIOD_W-1:0];
                r_quot <= {r_quot[QUOT_W-2:0], n_ge};
                r_cnt  <= r_cnt + 1'b1;
                r_done <= (r_cnt == STEP_CW'(QUOT_W - 1));
                if (r_cnt == STEP_CW'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule

// ===== design/tremolo_amplitude_modulator_top.sv =====
// Tremolo amplitude modulator: oscillator position, serial divide, gain and sample scaling.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_sample_in, i_block_end_in
//   out     | output    | o_out_valid / i_out_ready  | o_sample_out, o_block_end_out
//   cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Each sample passes the 16-step restoring divide of the oscillator fraction;
// ST_DIV then latches the fraction, ST_SQ and ST_GAIN form the gain, ST_MUL forms
// the product, and ST_OUT writes the result once the output register is free.
// A new sample is taken once the previous one has left the arithmetic, even while
// its result still waits in the output register.
// Synchronous active-low reset restores the register defaults and zeroes the position.
// The cfg port is always ready.
module tremolo_amplitude_modulator_top
    import tam_pkg::*;
#(
    parameter int COUNT_WIDTH = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample_in,
    input  logic                  i_block_end_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SAMPLE_W-1:0]   o_sample_out,
    output logic                  o_block_end_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int EW = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQ,
        ST_GAIN,
        ST_MUL,
        ST_OUT
    } t_state;

    t_state r_state;

    logic [PERIOD_W-1:0]     r_half_cycle;
    t_wave                   r_wave_mode;
    logic [DEPTH_W-1:0]      r_depth;
    logic [COUNT_WIDTH-1:0]  r_phase;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_block_end;
    logic                       r_low_half;
    logic [QUOT_W-1:0]          r_u;
    logic [GAIN_W-1:0]          r_gain;
    logic [GS_W-1:0]            r_gs;
    logic signed [34:0]         r_prod;
    logic                       r_out_valid;
    logic [SAMPLE_W-1:0]        r_sample_out;
    logic                       r_block_end_out;

    logic [PERIOD_W-1:0]    n_period;
    logic [EW-1:0]          n_pos_ext;
    logic [EW-1:0]          n_pos_red;
    logic [COUNT_WIDTH-1:0] n_pos_inc;
    logic [EW-1:0]          n_inc_ext;
    logic [COUNT_WIDTH-1:0] n_phase;
    logic                   n_accept;

    logic signed [17:0]     n_t;
    logic signed [35:0]     n_tsq;
    logic [GAIN_W-1:0]      n_gain;
    logic [32:0]            n_gd;
    logic signed [34:0]     n_prod;
    logic signed [34:0]     n_adj;
    logic signed [34:0]     n_quo;
    logic [SAMPLE_W-1:0]    n_sat;

    t_div_res w_div;

    assign n_accept = i_in_valid && o_in_ready;

    // Oscillator position: fold back to zero when at or past the period
    always_comb begin
        n_period  = (r_half_cycle == '0) ? PERIOD_W'(1) : r_half_cycle;
        n_pos_ext = EW'(r_phase);
        n_pos_red = (n_pos_ext >= EW'(n_period)) ? '0 : n_pos_ext;
        n_pos_inc = n_pos_red[COUNT_WIDTH-1:0] + 1'b1;
        n_inc_ext = EW'(n_pos_inc);
        n_phase   = (n_inc_ext >= EW'(n_period)) ? '0 : n_pos_inc;
    end

    tam_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_accept),
        .i_dividend (n_pos_red[PERIOD_W-1:0]),
        .i_divisor  (n_period),
        .o_res      (w_div)
    );

    always_comb begin
        n_t   = $signed({1'b0, r_u, 1'b0}) - 18'sd65536;
        n_tsq = n_t * n_t;
        case (r_wave_mode)
            WAVE_SQUARE:   n_gain = r_low_half ? GAIN_W'(0) : GAIN_W'(65536);
            WAVE_TRIANGLE: n_gain = {1'b0, r_u};
            WAVE_PARABOLA: n_gain = GAIN_W'(65536) - {1'b0, n_tsq[32:17]};
            default:       n_gain = GAIN_W'(32768);
        endcase
        n_gd   = r_gain * r_depth;
        n_prod = r_sample * $signed({1'b0, r_gs});
        // Truncate toward zero, then clamp to the sample range
        n_adj  = r_prod + (r_prod[34] ? 35'sd65535 : 35'sd0);
        n_quo  = n_adj >>> 16;
        if (n_quo > 35'sd32767) begin
            n_sat = 16'h7FFF;
        end else if (n_quo < -35'sd32768) begin
            n_sat = 16'h8000;
        end else begin
            n_sat = n_quo[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_cycle <= RST_HALF_CYCLE;
            r_wave_mode  <= RST_WAVE_MODE;
            r_depth      <= RST_DEPTH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_CYCLE: r_half_cycle <= i_cfg_data[PERIOD_W-1:0];
                CFG_WAVE_MODE:  r_wave_mode  <= i_cfg_data[1:0];
                CFG_DEPTH:      r_depth      <= i_cfg_data[DEPTH_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop valid once taken, unless a new result replaces it this cycle
            if (r_out_valid && i_out_ready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_sample    <= $signed(i_sample_in);
                        r_block_end <= i_block_end_in;
                        r_low_half  <= (n_pos_red < EW'(n_period >> 1));
                        r_phase     <= n_phase;
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div.done) begin
                        r_u     <= w_div.quot;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_gain  <= n_gain;
                    r_state <= ST_GAIN;
                end
                ST_GAIN: begin
                    r_gs    <= n_gd[32:15];
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid     <= 1'b1;
                        r_sample_out    <= n_sat;
                        r_block_end_out <= r_block_end;
                        r_state         <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = r_sample_out;
    assign o_block_end_out = r_block_end_out;
    assign o_cfg_ready     = 1'b1;

endmodule

// ===== design/tam_checker.sv =====
// Port-level checks for the tremolo amplitude modulator, bound to the top level.
module tam_checker
    import tam_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [SAMPLE_W-1:0]   o_sample_out,
    input logic                  o_block_end_out
);

    // One transaction in flight: acceptance closes the input side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a sample is still in the arithmetic");

    // A result appears exactly as the input side reopens
    a_result_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready && !$past(o_in_ready))
        else $error("result appeared without finishing a sample");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_sample_out) && $stable(o_block_end_out))
        else $error("output payload changed while stalled");

endmodule

bind tremolo_amplitude_modulator_top tam_checker u_tam_checker (.*);

// ===== tb/tb_tremolo_amplitude_modulator_top.sv =====
// Self-checking testbench for the tremolo amplitude modulator top level.
`timescale 1ns / 100ps

module tb_tremolo_amplitude_modulator_top;
    import tam_pkg::*;

    localparam int       COUNT_W      = 20;
    localparam int       CYCLE_LIMIT  = 600000;
    localparam int       RANDOM_ITEMS = 1100;
    localparam int       TAIL_CYCLES  = 40;
    localparam t_cfg_idx CFG_UNUSED   = 2'd3;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                block_end;
    } modulated_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [SAMPLE_W-1:0]   i_sample_in;
    logic                  i_block_end_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [SAMPLE_W-1:0]   o_sample_out;
    logic                  o_block_end_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the block's registers and oscillator position
    logic [PERIOD_W-1:0] half_cycle_m;
    t_wave               wave_m;
    logic [DEPTH_W-1:0]  depth_m;
    logic [COUNT_W-1:0]  phase_m;

    modulated_t expected_q[$];

    int cycle_count;
    int items_sent;
    int results_seen;
    int mismatches;
    int reg_writes;
    int phases_run;
    int burst_left;

    rx_mode_t rx_mode;
    int       rx_left;

    tremolo_amplitude_modulator_top #(
        .COUNT_WIDTH(COUNT_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_in    (i_sample_in),
        .i_block_end_in (i_block_end_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_out   (o_sample_out),
        .o_block_end_out(o_block_end_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure: switch at random between stall patterns
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(32, 256);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   i_out_ready = 1'b1;
            RX_COIN:   i_out_ready = 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready = (rx_left % 8) == 0;
            default:   i_out_ready = (rx_left % 16) < 12;
        endcase
    end

    // Compare each output transaction with the oldest predicted sample
    always @(posedge i_clk) begin
        modulated_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sample=%0d end=%0b",
                             $signed(o_sample_out), o_block_end_out);
            end else begin
                want = expected_q.pop_front();
                if (o_sample_out !== want.sample || o_block_end_out !== want.block_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected sample=%0d end=%0b, got sample=%0d end=%0b",
                                 results_seen, $signed(want.sample), want.block_end,
                                 $signed(o_sample_out), o_block_end_out);
                end
            end
        end
    end

    function automatic void reset_shadow();
        half_cycle_m = RST_HALF_CYCLE;
        wave_m       = RST_WAVE_MODE;
        depth_m      = RST_DEPTH;
        phase_m      = '0;
    endfunction

    function automatic void apply_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_HALF_CYCLE: half_cycle_m = data[PERIOD_W-1:0];
            CFG_WAVE_MODE:  wave_m       = data[1:0];
            CFG_DEPTH:      depth_m      = data[DEPTH_W-1:0];
            default: ;
        endcase
    endfunction

    // Scale one sample by the oscillator gain and advance the position
    function automatic modulated_t predict_tremolo(input logic [SAMPLE_W-1:0] smp,
                                                   input logic be);
        u64_t       period;
        u64_t       pos;
        u64_t       frac;
        u64_t       gain;
        u64_t       scaled;
        longint     dev;
        longint     s;
        longint     r;
        modulated_t res;
        period = (half_cycle_m == 0) ? 1 : u64_t'(half_cycle_m);
        pos    = u64_t'(phase_m);
        if (pos >= period)
            pos = 0;
        frac = (pos << 16) / period;
        case (wave_m)
            WAVE_SQUARE:   gain = (pos < (period >> 1)) ? 0 : 65536;
            WAVE_TRIANGLE: gain = frac;
            WAVE_PARABOLA: begin
                dev  = longint'(frac) * 2 - 65536;
                gain = 65536 - (u64_t'(dev * dev) >> 17);
            end
            default:       gain = 32768;
        endcase
        scaled = (gain * u64_t'(depth_m)) >> 15;
        s      = longint'(signed'(smp));
        r      = (s * longint'(scaled)) / 65536;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        pos = (pos + 1) & ((u64_t'(1) << COUNT_W) - 1);
        if (pos >= period)
            pos = 0;
        phase_m       = pos[COUNT_W-1:0];
        res.sample    = r[SAMPLE_W-1:0];
        res.block_end = be;
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one sample; the sender may idle between bursts of random length
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic be);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     = 1'b1;
        i_sample_in    = smp;
        i_block_end_in = be;
        do @(posedge i_clk); while (!o_in_ready);
        expected_q.push_back(predict_tremolo(smp, be));
        items_sent++;
    endtask

    // Drop valid and hold until every predicted sample has come out
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        settle_block();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
    endtask

    task automatic test_wave_shapes();
        // Position has reached the new period here, so it restarts at zero
        write_reg(CFG_HALF_CYCLE, 20'd3);
        write_reg(CFG_WAVE_MODE, 20'(WAVE_SQUARE));
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h8000, 1'b0);
        write_reg(CFG_HALF_CYCLE, 20'd5);
        write_reg(CFG_WAVE_MODE, 20'(WAVE_PARABOLA));
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h4000, 1'b1);
        write_reg(CFG_WAVE_MODE, 20'(WAVE_HALF));
        send_sample(16'h8000, 1'b0);
    endtask

    task automatic test_corner_settings();
        write_reg(CFG_HALF_CYCLE, 20'd0);
        write_reg(CFG_WAVE_MODE, 20'(WAVE_TRIANGLE));
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        // Depth above one drives the product past 16 bits
        write_reg(CFG_HALF_CYCLE, 20'd2);
        write_reg(CFG_WAVE_MODE, 20'(WAVE_SQUARE));
        write_reg(CFG_DEPTH, 20'hFFFF);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        write_reg(CFG_DEPTH, 20'd0);
        send_sample(16'h8000, 1'b0);
        write_reg(CFG_UNUSED, 20'hFFFFF);
        write_reg(CFG_DEPTH, 20'd32768);
        send_sample(16'h8000, 1'b0);
        // Shrink the period under a running position
        write_reg(CFG_HALF_CYCLE, 20'd40);
        write_reg(CFG_WAVE_MODE, 20'(WAVE_TRIANGLE));
        repeat (4) send_sample(pick_sample(), 1'b0);
        write_reg(CFG_HALF_CYCLE, 20'd3);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
    endtask

    task automatic test_random_phases();
        int                    sent;
        int                    count;
        logic [CFG_DATA_W-1:0] data;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       data = 20'd0;
                1:       data = 20'd1;
                2:       data = 20'hFFFFF;
                3:       data = 20'($urandom);
                default: data = 20'($urandom_range(2, 80));
            endcase
            write_reg(CFG_HALF_CYCLE, data);
            data = (20'($urandom) & 20'hFFFFC) | 20'(phases_run % 4);
            write_reg(CFG_WAVE_MODE, data);
            case ($urandom_range(0, 5))
                0:       data = 20'd0;
                1:       data = 20'd32768;
                2:       data = 20'hFFFF;
                3:       data = 20'($urandom);
                default: data = 20'($urandom_range(0, 32768));
            endcase
            write_reg(CFG_DEPTH, data);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, 20'($urandom));
            phases_run++;
            count = $urandom_range(60, 120);
            repeat (count) send_sample(pick_sample(), ($urandom_range(0, 7) == 0));
            sent += count;
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_sample_in    = '0;
        i_block_end_in = 1'b0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_HALF_CYCLE;
        i_cfg_data     = '0;
        cycle_count    = 0;
        items_sent     = 0;
        results_seen   = 0;
        mismatches     = 0;
        reg_writes     = 0;
        phases_run     = 0;
        burst_left     = 0;
        rx_mode        = RX_OPEN;
        rx_left        = 0;
        reset_shadow();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_wave_shapes();
        test_corner_settings();
        test_random_phases();

        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d samples over %0d random setups, %0d register writes",
                 items_sent, phases_run, reg_writes);
        $display("checked %0d results, %0d mismatches, %0d still pending",
                 results_seen, mismatches, expected_q.size());
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== tremolo_amplitude_modulator_top.f =====
design/tam_pkg.sv
design/tam_div.sv
design/tremolo_amplitude_modulator_top.sv
design/tam_checker.sv
tb/tb_tremolo_amplitude_modulator_top.sv
